// ----- rtl/ffsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_IGNORED    = 3'd1;
	localparam logic [2:0] ST_NO_MEMORY  = 3'd2;
	localparam logic [2:0] ST_MISMATCH   = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
	localparam logic [2:0] ST_TABLE_FULL = 3'd5;

	localparam logic OP_ALLOCATE   = 1'b0;
	localparam logic OP_DEALLOCATE = 1'b1;

	localparam logic CFG_SEGMENT_BASE = 1'b0;
	localparam logic CFG_SEGMENT_SIZE = 1'b1;

	typedef struct packed {
		logic        free;
		logic [31:0] len;
		logic [31:0] start;
	} entry_t;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_LOAD,
		DP_INIT,
		DP_RD_IDX,
		DP_CAP_CUR,
		DP_NEXT,
		DP_OPEN_SET,
		DP_RD_K,
		DP_MOVE_UP,
		DP_RD_K1,
		DP_MOVE_DN,
		DP_CNT_DEC,
		DP_SPLIT_A,
		DP_SPLIT_B,
		DP_TAKE,
		DP_RD_NEXT,
		DP_RD_PREV,
		DP_CAP_NB,
		DP_MERGE_NEXT,
		DP_WR_PREV,
		DP_WR_CUR_FREE,
		DP_DONE_ST,
		DP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic init_pend;
		logic operation;
		logic size_zero;
		logic addr_zero;
		logic idx_last;
		logic idx_zero;
		logic fit;
		logic len_eq;
		logic full;
		logic match;
		logic nb_free;
		logic k_eq_idx;
		logic k1_lt_cnt;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/ffsa_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ffsa_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] request_size;
	logic [31:0] block_address;

	modport source (output valid, operation, request_size, block_address, input ready);
	modport sink (input valid, operation, request_size, block_address, output ready);
endinterface

interface ffsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_address;
	logic [2:0]  status;

	modport source (output valid, result_address, status, input ready);
	modport sink (input valid, result_address, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffsa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/ffsa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffsa_datapath import ffsa_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic     in_operation,
	input  wire logic [31:0] in_request_size,
	input  wire logic [31:0] in_block_address,
	input  wire dp_cmd_t  cmd,
	output dp_stat_t      stat,
	output logic [31:0]   out_result_address,
	output logic [2:0]    out_status
);
	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

	logic [31:0]   base_q, size_cfg_q;
	logic          init_q;
	logic          op_q;
	logic [31:0]   size_q, addr_q;
	logic [CW-1:0] idx_q, k_q, count_q;
	entry_t        cur_q, nb_q;
	logic [31:0]   res_addr_q;
	logic [2:0]    res_st_q;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	entry_t        wdata, rdata;
	logic [CW-1:0] idx_p1, idx_m1, k_p1, k_m1;

	assign idx_p1 = idx_q + CW'(1);
	assign idx_m1 = idx_q - CW'(1);
	assign k_p1   = k_q + CW'(1);
	assign k_m1   = k_q - CW'(1);

	ffsa_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = cur_q;
		raddr = idx_q[IW-1:0];
		case (cmd.op)
			DP_INIT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = '{free: 1'b1, len: size_cfg_q, start: base_q};
			end
			DP_RD_K:    raddr = k_q[IW-1:0];
			DP_RD_K1:   raddr = k_p1[IW-1:0];
			DP_RD_NEXT: raddr = idx_p1[IW-1:0];
			DP_RD_PREV: raddr = idx_m1[IW-1:0];
			DP_MOVE_UP: begin
				we    = 1'b1;
				waddr = k_p1[IW-1:0];
				wdata = rdata;
			end
			DP_MOVE_DN: begin
				we    = 1'b1;
				waddr = k_q[IW-1:0];
				wdata = rdata;
			end
			DP_SPLIT_A: begin
				we    = 1'b1;
				wdata = '{free: 1'b0, len: size_q, start: cur_q.start};
			end
			DP_SPLIT_B: begin
				we    = 1'b1;
				waddr = idx_p1[IW-1:0];
				wdata = '{free: 1'b1, len: cur_q.len - size_q, start: cur_q.start + size_q};
			end
			DP_TAKE: begin
				we    = 1'b1;
				wdata = '{free: 1'b0, len: cur_q.len, start: cur_q.start};
			end
			DP_WR_PREV: begin
				we    = 1'b1;
				waddr = idx_m1[IW-1:0];
				wdata = '{free: 1'b1, len: nb_q.len + cur_q.len, start: nb_q.start};
			end
			DP_WR_CUR_FREE: begin
				we    = 1'b1;
				wdata = '{free: 1'b1, len: cur_q.len, start: cur_q.start};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			size_cfg_q <= '0;
			init_q     <= 1'b1;
			count_q    <= CW'(1);
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SEGMENT_BASE) begin
					base_q <= cfg_wdata;
				end else begin
					size_cfg_q <= cfg_wdata;
				end
				init_q <= 1'b1;
			end
			case (cmd.op)
				DP_INIT: begin
					init_q  <= 1'b0;
					count_q <= CW'(1);
				end
				DP_CNT_DEC: count_q <= count_q - CW'(1);
				DP_SPLIT_B: count_q <= count_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				op_q   <= in_operation;
				size_q <= in_request_size;
				addr_q <= in_block_address;
				idx_q  <= '0;
			end
			DP_CAP_CUR:  cur_q <= rdata;
			DP_CAP_NB:   nb_q <= rdata;
			DP_NEXT:     idx_q <= idx_p1;
			DP_OPEN_SET: k_q <= count_q - CW'(1);
			DP_MOVE_UP:  k_q <= k_m1;
			DP_MOVE_DN:  k_q <= k_p1;
			DP_SPLIT_A: begin
				res_addr_q <= cur_q.start;
				res_st_q   <= ST_OK;
			end
			DP_TAKE: begin
				res_addr_q <= cur_q.start;
				res_st_q   <= ST_OK;
			end
			DP_MERGE_NEXT: begin
				cur_q.len <= cur_q.len + nb_q.len;
				k_q       <= idx_p1;
			end
			DP_WR_PREV: k_q <= idx_q;
			DP_DONE_ST: begin
				res_addr_q <= '0;
				res_st_q   <= cmd.st;
			end
			DP_PUBLISH: begin
				out_result_address <= res_addr_q;
				out_status         <= res_st_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.init_pend = init_q;
		stat.operation = op_q;
		stat.size_zero = (size_q == '0);
		stat.addr_zero = (addr_q == '0);
		stat.idx_last  = (idx_p1 >= count_q);
		stat.idx_zero  = (idx_q == '0);
		stat.fit       = cur_q.free && (cur_q.len >= size_q);
		stat.len_eq    = (cur_q.len == size_q);
		stat.full      = (count_q >= CNT_MAX);
		stat.match     = (cur_q.start == addr_q);
		stat.nb_free   = nb_q.free;
		stat.k_eq_idx  = (k_q == idx_q);
		stat.k1_lt_cnt = (k_p1 < count_q);
	end
endmodule
`default_nettype wire

// ----- rtl/ffsa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ctrl import ffsa_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);
	typedef enum logic [4:0] {
		S_IDLE, S_START, S_SC_RD, S_SC_CAP, S_SC_EVAL,
		S_OPN_RD, S_OPN_MV, S_SPL_A, S_SPL_B,
		S_NX_CAP, S_NX_EVAL, S_RM_CHK, S_RM_MV,
		S_PV_CHK, S_PV_CAP, S_PV_EVAL, S_DONE_OK, S_FIN
	} state_t;

	state_t state_q, state_d, ret_q, ret_d;
	logic   publish;

	assign in_ready = (state_q == S_IDLE);
	assign publish  = (state_q == S_FIN) && (!out_valid || out_ready);

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd.op  = DP_NONE;
		cmd.st  = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_d = S_START;
				end
			end
			S_START: begin
				if (stat.init_pend) begin
					cmd.op = DP_INIT;
				end else if ((stat.operation == OP_ALLOCATE && stat.size_zero) ||
						(stat.operation == OP_DEALLOCATE && stat.addr_zero)) begin
					cmd.op  = DP_DONE_ST;
					cmd.st  = ST_IGNORED;
					state_d = S_FIN;
				end else begin
					state_d = S_SC_RD;
				end
			end
			S_SC_RD: begin
				cmd.op  = DP_RD_IDX;
				state_d = S_SC_CAP;
			end
			S_SC_CAP: begin
				cmd.op  = DP_CAP_CUR;
				state_d = S_SC_EVAL;
			end
			S_SC_EVAL: begin
				if (stat.operation == OP_ALLOCATE) begin
					if (stat.fit) begin
						if (stat.len_eq) begin
							cmd.op  = DP_TAKE;
							state_d = S_FIN;
						end else if (stat.full) begin
							cmd.op  = DP_DONE_ST;
							cmd.st  = ST_TABLE_FULL;
							state_d = S_FIN;
						end else begin
							cmd.op  = DP_OPEN_SET;
							state_d = S_OPN_RD;
						end
					end else if (stat.idx_last) begin
						cmd.op  = DP_DONE_ST;
						cmd.st  = ST_NO_MEMORY;
						state_d = S_FIN;
					end else begin
						cmd.op  = DP_NEXT;
						state_d = S_SC_RD;
					end
				end else begin
					if (stat.match) begin
						if (!stat.len_eq) begin
							cmd.op  = DP_DONE_ST;
							cmd.st  = ST_MISMATCH;
							state_d = S_FIN;
						end else if (stat.idx_last) begin
							state_d = S_PV_CHK;
						end else begin
							cmd.op  = DP_RD_NEXT;
							state_d = S_NX_CAP;
						end
					end else if (stat.idx_last) begin
						cmd.op  = DP_DONE_ST;
						cmd.st  = ST_NOT_FOUND;
						state_d = S_FIN;
					end else begin
						cmd.op  = DP_NEXT;
						state_d = S_SC_RD;
					end
				end
			end
			S_OPN_RD: begin
				cmd.op  = DP_RD_K;
				state_d = S_OPN_MV;
			end
			S_OPN_MV: begin
				cmd.op  = DP_MOVE_UP;
				state_d = stat.k_eq_idx ? S_SPL_A : S_OPN_RD;
			end
			S_SPL_A: begin
				cmd.op  = DP_SPLIT_A;
				state_d = S_SPL_B;
			end
			S_SPL_B: begin
				cmd.op  = DP_SPLIT_B;
				state_d = S_FIN;
			end
			S_NX_CAP: begin
				cmd.op  = DP_CAP_NB;
				state_d = S_NX_EVAL;
			end
			S_NX_EVAL: begin
				if (stat.nb_free) begin
					cmd.op  = DP_MERGE_NEXT;
					ret_d   = S_PV_CHK;
					state_d = S_RM_CHK;
				end else begin
					state_d = S_PV_CHK;
				end
			end
			S_RM_CHK: begin
				if (stat.k1_lt_cnt) begin
					cmd.op  = DP_RD_K1;
					state_d = S_RM_MV;
				end else begin
					cmd.op  = DP_CNT_DEC;
					state_d = ret_q;
				end
			end
			S_RM_MV: begin
				cmd.op  = DP_MOVE_DN;
				state_d = S_RM_CHK;
			end
			S_PV_CHK: begin
				if (stat.idx_zero) begin
					cmd.op  = DP_WR_CUR_FREE;
					state_d = S_DONE_OK;
				end else begin
					cmd.op  = DP_RD_PREV;
					state_d = S_PV_CAP;
				end
			end
			S_PV_CAP: begin
				cmd.op  = DP_CAP_NB;
				state_d = S_PV_EVAL;
			end
			S_PV_EVAL: begin
				if (stat.nb_free) begin
					cmd.op  = DP_WR_PREV;
					ret_d   = S_DONE_OK;
					state_d = S_RM_CHK;
				end else begin
					cmd.op  = DP_WR_CUR_FREE;
					state_d = S_DONE_OK;
				end
			end
			S_DONE_OK: begin
				cmd.op  = DP_DONE_ST;
				cmd.st  = ST_OK;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (publish) begin
					cmd.op  = DP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (publish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/first_fit_segment_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// First-fit segment allocator with coalescing. The block table lives in a single-port-write,
// registered-read RAM of MAX_BLOCKS entries, and one request is handled at a time by a scan
// over the table: each entry inspected is read, captured and evaluated, and the entries from
// there on are shifted one place (read, then moved) when an allocate splits a block or a
// release merges with a neighbour; an ignored request skips the scan. The scan and the
// shifts share the RAM read port. Writing segment_base or segment_size resets the table to
// one free block, taking effect at the start of the next request. A finished result is held
// in an output register, so a new request is taken while it waits.
module first_fit_segment_allocator import ffsa_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	ffsa_req_if.sink         req,
	ffsa_rsp_if.source       rsp
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	ffsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffsa_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.in_operation       (req.operation),
		.in_request_size    (req.request_size),
		.in_block_address   (req.block_address),
		.cmd                (cmd),
		.stat               (stat),
		.out_result_address (rsp.result_address),
		.out_status         (rsp.status)
	);
endmodule
`default_nettype wire
